@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by scl_queue and scl_back.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every sampled edge
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// ante implies cons in the same cycle
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/scl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_pkg
// Types and constants of the shell command lexer.
// ----------------------------------------------------------------------------
package scl_pkg;

    typedef enum logic [2:0] {
        TK_WORD   = 3'd0,
        TK_PIPE   = 3'd1,
        TK_OUT    = 3'd2,
        TK_APPEND = 3'd3,
        TK_IN     = 3'd4,
        TK_SEMI   = 3'd5,
        TK_AMP    = 3'd6,
        TK_END    = 3'd7
    } tok_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WORD  = 2'd1,
        MODE_QUOTE = 2'd2,
        MODE_GT    = 2'd3
    } lex_mode_t;

    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_QMARK  = 8'h3F;

    // results one input item can cause
    localparam int MAX_RES = 3;
    // groups held between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        tok_kind_t  token_kind;
        logic       char_valid;
        logic [7:0] char_value;
        logic       token_done;
        logic       last;
    } out_item_t;

    // all results of one input item, count is 1..MAX_RES
    typedef struct packed {
        logic [1:0]                 count;
        out_item_t [MAX_RES-1:0]    res;
    } res_group_t;

endpackage

@@ hw/rtl/scl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_front
// Lexer state machine: classify one byte per cycle, while the queue is not full, into a result group.
// ----------------------------------------------------------------------------
module scl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scl_pkg::in_item_t   item,
    input  logic                q_full,
    output logic                full,
    output logic                q_push,
    output scl_pkg::res_group_t q_data
);
    import scl_pkg::*;

    typedef struct packed {
        logic       emit;
        out_item_t  res;
        lex_mode_t  mode;
        logic       set_quote;
        logic       qsingle;
    } start_t;

    lex_mode_t mode_reg, mode_next;
    logic      qsingle_reg, qsingle_next;
    logic      esc_reg, esc_next;
    logic      accept;

    function automatic out_item_t mk(tok_kind_t k, logic cv, logic [7:0] ch, logic done);
        out_item_t r;
        r.token_kind = k;
        r.char_valid = cv;
        r.char_value = cv ? ch : 8'h00;
        r.token_done = done;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic starts_word(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == CH_DOT || c == CH_SLASH ||
               c == CH_BSLASH || c == CH_DASH || c == CH_UNDER || c == CH_TILDE ||
               c == CH_STAR || c == CH_QMARK;
    endfunction

    function automatic start_t start_token(logic [7:0] c);
        start_t s;
        s = '0;
        s.mode = MODE_IDLE;
        if (is_space(c)) begin
            s.emit = 1'b0;
        end else if (c == CH_PIPE) begin
            s.emit = 1'b1;
            s.res  = mk(TK_PIPE, 1'b0, 8'h00, 1'b1);
        end else if (c == CH_LT) begin
            s.emit = 1'b1;
            s.res  = mk(TK_IN, 1'b0, 8'h00, 1'b1);
        end else if (c == CH_SEMI) begin
            s.emit = 1'b1;
            s.res  = mk(TK_SEMI, 1'b0, 8'h00, 1'b1);
        end else if (c == CH_AMP) begin
            s.emit = 1'b1;
            s.res  = mk(TK_AMP, 1'b0, 8'h00, 1'b1);
        end else if (c == CH_GT) begin
            s.mode = MODE_GT;
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            s.set_quote = 1'b1;
            s.qsingle   = (c == CH_SQUOTE);
            s.mode      = MODE_QUOTE;
        end else if (starts_word(c)) begin
            s.emit = 1'b1;
            s.res  = mk(TK_WORD, 1'b1, c, 1'b0);
            s.mode = MODE_WORD;
        end
        return s;
    endfunction

    assign full   = q_full;
    assign accept = push && !q_full;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg    <= MODE_IDLE;
            qsingle_reg <= 1'b0;
            esc_reg     <= 1'b0;
        end else if (accept) begin
            mode_reg    <= mode_next;
            qsingle_reg <= qsingle_next;
            esc_reg     <= esc_next;
        end
    end

    always_comb begin
        logic [7:0] c;
        logic [7:0] qc;
        logic [1:0] cnt;
        start_t     st;

        c            = item.byte_value;
        qc           = qsingle_reg ? CH_SQUOTE : CH_DQUOTE;
        cnt          = 2'd0;
        st           = '0;
        q_data       = '0;
        mode_next    = mode_reg;
        qsingle_next = qsingle_reg;
        esc_next     = esc_reg;

        if (item.kind) begin
            // close whatever is open, then END
            if (mode_reg == MODE_WORD) begin
                q_data.res[cnt] = mk(TK_WORD, 1'b0, 8'h00, 1'b1);
                cnt = cnt + 2'd1;
            end else if (mode_reg == MODE_GT) begin
                q_data.res[cnt] = mk(TK_OUT, 1'b0, 8'h00, 1'b1);
                cnt = cnt + 2'd1;
            end else if (mode_reg == MODE_QUOTE) begin
                if (esc_reg) begin
                    q_data.res[cnt] = mk(TK_WORD, 1'b1, CH_BSLASH, 1'b0);
                    cnt = cnt + 2'd1;
                end
                q_data.res[cnt] = mk(TK_WORD, 1'b0, 8'h00, 1'b1);
                cnt = cnt + 2'd1;
            end
            q_data.res[cnt] = mk(TK_END, 1'b0, 8'h00, 1'b1);
            cnt = cnt + 2'd1;
            mode_next    = MODE_IDLE;
            qsingle_next = 1'b0;
            esc_next     = 1'b0;
        end else begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    st = start_token(c);
                end
                MODE_WORD: begin
                    if (is_space(c) || c == CH_PIPE || c == CH_GT || c == CH_LT ||
                        c == CH_SEMI) begin
                        q_data.res[cnt] = mk(TK_WORD, 1'b0, 8'h00, 1'b1);
                        cnt = cnt + 2'd1;
                        st = start_token(c);
                    end else begin
                        q_data.res[cnt] = mk(TK_WORD, 1'b1, c, 1'b0);
                        cnt = cnt + 2'd1;
                    end
                end
                MODE_GT: begin
                    if (c == CH_GT) begin
                        q_data.res[cnt] = mk(TK_APPEND, 1'b0, 8'h00, 1'b1);
                        cnt = cnt + 2'd1;
                        mode_next = MODE_IDLE;
                    end else begin
                        q_data.res[cnt] = mk(TK_OUT, 1'b0, 8'h00, 1'b1);
                        cnt = cnt + 2'd1;
                        st = start_token(c);
                    end
                end
                MODE_QUOTE: begin
                    if (esc_reg && c == qc) begin
                        // escaped closing quote stands for itself
                        esc_next = 1'b0;
                        q_data.res[cnt] = mk(TK_WORD, 1'b1, c, 1'b0);
                        cnt = cnt + 2'd1;
                    end else begin
                        if (esc_reg) begin
                            // keep the backslash, then handle the byte afresh
                            esc_next = 1'b0;
                            q_data.res[cnt] = mk(TK_WORD, 1'b1, CH_BSLASH, 1'b0);
                            cnt = cnt + 2'd1;
                        end
                        if (c == qc) begin
                            q_data.res[cnt] = mk(TK_WORD, 1'b0, 8'h00, 1'b1);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_IDLE;
                        end else if (c == CH_BSLASH) begin
                            esc_next = 1'b1;
                        end else begin
                            q_data.res[cnt] = mk(TK_WORD, 1'b1, c, 1'b0);
                            cnt = cnt + 2'd1;
                        end
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase

            // apply a token start decided above
            if (mode_reg == MODE_IDLE ||
                (mode_reg == MODE_WORD && cnt == 2'd1 && q_data.res[0].token_done) ||
                (mode_reg == MODE_GT && c != CH_GT)) begin
                if (st.emit) begin
                    q_data.res[cnt] = st.res;
                    cnt = cnt + 2'd1;
                end
                mode_next = st.mode;
                if (st.set_quote) begin
                    qsingle_next = st.qsingle;
                    esc_next     = 1'b0;
                end
            end
        end

        if (cnt != 2'd0) begin
            q_data.res[cnt - 2'd1].last = 1'b1;
        end
        q_data.count = cnt;
        q_push       = accept && (cnt != 2'd0);
    end

endmodule

@@ hw/rtl/scl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_queue
// Short queue of result groups between the lexer and the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  scl_pkg::res_group_t wr_data,
    output logic                q_full,
    output logic                rd_valid,
    output scl_pkg::res_group_t rd_data,
    input  logic                rd_pop
);
    import scl_pkg::*;

    res_group_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]       count_reg, count_next;

    assign q_full   = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!wr_en && rd_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_IMPLY(a_no_write_full, wr_en, !q_full)
    `ASSERT_IMPLY(a_no_pop_empty, rd_pop, rd_valid)
    `ASSERT_NEXT(a_count_up, wr_en && !rd_pop, count_reg == $past(count_reg) + 1'b1)
    `ASSERT_IMPLY(a_group_nonempty, wr_en, wr_data.count != 2'd0)

endmodule

@@ hw/rtl/scl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_back
// Output stage: walk each result group and present one result per transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_valid,
    input  scl_pkg::res_group_t rd_data,
    output logic                rd_pop,
    output logic                empty,
    output scl_pkg::out_item_t  result,
    input  logic                pop
);
    import scl_pkg::*;

    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       group_end;

    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    // refill the output register when a group waits and the register is free or being taken
    assign load      = rd_valid && (!out_valid_reg || pop);
    assign group_end = (idx_reg == rd_data.count - 2'd1);
    assign rd_pop    = load && group_end;

    always_comb begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            idx_next       = group_end ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            out_reg <= rd_data.res[idx_reg];
        end
    end

    `ASSERT_IMPLY(a_idx_in_group, rd_valid, idx_reg < rd_data.count)
    `ASSERT_IMPLY(a_char_zero, out_valid_reg && !out_reg.char_valid, out_reg.char_value == 8'h00)
    `ASSERT_IMPLY(a_char_open, out_valid_reg && out_reg.char_valid,
        !out_reg.token_done && out_reg.token_kind == TK_WORD)

endmodule

@@ hw/rtl/shell_command_lexer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_command_lexer_unit
// Streaming shell command lexer: bytes in, word characters and tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive item (kind, byte_value) and raise push; a transfer
//   happens at a clock edge with push high and full low. kind = 1 marks the
//   end of input, which closes any open token, emits END and returns the
//   lexer to idle.
//   Result queue side: while empty is low the oldest result sits on result;
//   raise pop to transfer it. The last flag marks the final result of an item.
//   A result is written into the queue at its item's transfer and is then
//   loaded into the output register, from which it can be popped.
//   Throughput: one item per cycle while full is low, as long as each item
//   gives at most one result; the output stage issues one result per cycle
//   while pop is high, so an item that gives two or three results holds it
//   for each of them. A four-group queue between the lexer and the output
//   stage absorbs such bursts. Items that give no result (whitespace, skipped
//   bytes, a held '>') pass through the lexer and never enter the queue.
//   A stalled receiver holds the result; the queue fills and full rises.
//   Reset clears lexer state, the queue and the output valid flag; nothing
//   is emitted until the first item after reset.
// ----------------------------------------------------------------------------
module shell_command_lexer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  scl_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output scl_pkg::out_item_t result
);
    import scl_pkg::*;

    logic       q_full;
    logic       q_push;
    res_group_t q_wr_data;
    logic       q_rd_valid;
    res_group_t q_rd_data;
    logic       q_rd_pop;

    // front: classify each byte into a group of up to three results
    scl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .q_full (q_full),
        .full   (full),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    // decouple the lexer from the output side
    scl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wr_data),
        .q_full   (q_full),
        .rd_valid (q_rd_valid),
        .rd_data  (q_rd_data),
        .rd_pop   (q_rd_pop)
    );

    // back: serialize each group, one result per transfer
    scl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (q_rd_valid),
        .rd_data  (q_rd_data),
        .rd_pop   (q_rd_pop),
        .empty    (empty),
        .result   (result),
        .pop      (pop)
    );

endmodule
